// ===== src/bfca_pkg.sv =====
// ============================================================================
// bfca_pkg - shared types and constants of the best-fit chunk allocator
// Widths, word structs, cell commands and status codes.
// ============================================================================
`default_nettype none

package bfca_pkg;

    localparam int GAP_N       = 32;
    localparam int ALLOC_N     = 32;
    localparam int CHUNK_BYTES = 128;
    localparam int CHUNK_SHIFT = $clog2(CHUNK_BYTES);

    localparam int ADDR_W   = 31;
    localparam int BYTES_W  = 25;
    localparam int MIB_W    = 5;
    localparam int START_W  = 17;
    localparam int CHUNKS_W = 18;
    localparam int GIDX_W   = $clog2(GAP_N);
    localparam int AIDX_W   = $clog2(ALLOC_N);
    localparam int GCNT_W   = $clog2(GAP_N + 1);
    localparam int ACNT_W   = $clog2(ALLOC_N + 1);
    localparam int CIDX_W   = ADDR_W - CHUNK_SHIFT;
    localparam int MIB_SHIFT = 20 - CHUNK_SHIFT;

    localparam logic [ADDR_W-1:0] BASE_ADDR = 31'h7000_0000;
    localparam logic [MIB_W-1:0]  MAX_MIB   = 5'd16;

    localparam logic FUNC_ALLOC = 1'b0;
    localparam logic FUNC_FREE  = 1'b1;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_DISABLED = 3'd1,
        ST_NOFIT    = 3'd2,
        ST_FULL     = 3'd3,
        ST_NOTFOUND = 3'd4,
        ST_ZERO     = 3'd5
    } t_status;

    typedef struct packed {
        logic                 func;
        logic [BYTES_W-1:0]   request_bytes;
        logic [ADDR_W-1:0]    free_address;
    } t_in_word;

    typedef struct packed {
        logic [ADDR_W-1:0]    granted_address;
        logic [2:0]           status;
    } t_out_word;

    // gap row
    typedef enum logic {GM_FIT, GM_MERGE} t_gmode;
    typedef enum logic [1:0] {MG_EMPTY, MG_BELOW, MG_ABOVE} t_merge;

    typedef struct packed {
        t_gmode               mode;
        logic [CHUNKS_W-1:0]  need;
        logic [START_W-1:0]   s;
        logic [CHUNKS_W-1:0]  n;
        logic [GCNT_W-1:0]    used;
    } t_gqry;

    typedef struct packed {
        logic                 valid;
        logic                 found;
        logic                 exact;
        logic [GIDX_W-1:0]    idx;
        logic [CHUNKS_W-1:0]  chunks;
        logic [START_W-1:0]   start;
        t_merge               merge;
    } t_gtok;

    typedef enum logic [2:0] {
        GC_NONE, GC_INIT, GC_CARVE, GC_FILL, GC_GROW_UP, GC_GROW_DOWN
    } t_gcmd;

    typedef struct packed {
        t_gcmd                op;
        logic [GIDX_W-1:0]    idx;
        logic [START_W-1:0]   start;
        logic [CHUNKS_W-1:0]  chunks;
    } t_gwr;

    // allocation row
    typedef struct packed {
        logic [CIDX_W-1:0]    chunk;
        logic [ACNT_W-1:0]    used;
    } t_aqry;

    typedef struct packed {
        logic                 valid;
        logic                 found;
        logic [AIDX_W-1:0]    idx;
        logic [START_W-1:0]   start;
        logic [CHUNKS_W-1:0]  chunks;
    } t_atok;

    typedef enum logic [1:0] {AC_NONE, AC_CLEAR, AC_APPEND, AC_REMOVE} t_acmd;

    typedef struct packed {
        t_acmd                op;
        logic [AIDX_W-1:0]    idx;
        logic [START_W-1:0]   start;
        logic [CHUNKS_W-1:0]  chunks;
    } t_awr;

endpackage

`default_nettype wire

// ===== src/best_fit_chunk_allocator_unit.sv =====
// A search word walks the 32-cell gap row (and, for free, the 32-cell allocation row
// first) one cell per clock. No new word is accepted until the last result word is issued.
// Errors caught before a walk (disabled, zero size, address below base) skip the walk.
// Reset (synchronous, active low) clears both tables, the counts and the size register,
// leaving the allocator disabled until the memory size is written.
// ============================================================================
// best_fit_chunk_allocator_unit - best-fit chunk allocator, top level
// Sequencer driving a row of gap cells and a row of allocation cells.
// ============================================================================
`default_nettype none

module best_fit_chunk_allocator_unit (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // request channel
    input  wire logic                          i_in_valid,
    output logic                               o_in_stall,
    input  wire bfca_pkg::t_in_word            i_in_word,
    // result channel
    output logic                               o_out_valid,
    input  wire logic                          i_out_stall,
    output bfca_pkg::t_out_word                o_out_word,
    // memory size register
    input  wire logic                          i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire logic [bfca_pkg::MIB_W-1:0]    i_cfg_data
);
    import bfca_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_GSCAN = 4'b0010,
        S_ASCAN = 4'b0100,
        S_DONE  = 4'b1000
    } t_state;

    t_state              r_state, n_state;
    logic [MIB_W-1:0]    r_mib, n_mib;
    logic [GCNT_W-1:0]   r_gap_used, n_gap_used;
    logic [ACNT_W-1:0]   r_alloc_used, n_alloc_used;
    logic                r_func, n_func;
    logic [CHUNKS_W-1:0] r_need, n_need;
    logic [CIDX_W-1:0]   r_chunk, n_chunk;
    logic [START_W-1:0]  r_s, n_s;
    logic [CHUNKS_W-1:0] r_n, n_n;
    logic [AIDX_W-1:0]   r_k, n_k;
    t_gmode              r_gmode, n_gmode;
    logic                r_gtok_go, n_gtok_go;
    logic                r_atok_go, n_atok_go;
    t_gwr                r_gwr, n_gwr;
    t_awr                r_awr, n_awr;
    logic [ADDR_W-1:0]   r_res_addr, n_res_addr;
    t_status             r_res_st, n_res_st;
    logic                r_out_valid, n_out_valid;
    t_out_word           r_out_word, n_out_word;

    // search words travel along the rows; index 0 is the launch point
    t_gtok               w_gtok [GAP_N+1];
    t_atok               w_atok [ALLOC_N+1];
    logic [START_W-1:0]  w_astart  [ALLOC_N+1];
    logic [CHUNKS_W-1:0] w_achunks [ALLOC_N+1];
    t_gqry               w_gqry;
    t_aqry               w_aqry;

    logic                w_in_acc;
    logic                w_cfg_acc;
    logic                w_out_free;
    logic [BYTES_W:0]    w_round;
    logic [ADDR_W-1:0]   w_offset;
    logic [MIB_W-1:0]    w_mib_clamp;

    assign w_in_acc   = i_in_valid && (r_state == S_IDLE);
    assign w_cfg_acc  = i_cfg_valid && o_cfg_ready;
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_round    = {1'b0, i_in_word.request_bytes} + (BYTES_W+1)'(CHUNK_BYTES - 1);
    assign w_offset   = i_in_word.free_address - BASE_ADDR;
    assign w_mib_clamp = (i_cfg_data > MAX_MIB) ? MAX_MIB : i_cfg_data;

    assign w_gqry = '{mode: r_gmode, need: r_need, s: r_s, n: r_n, used: r_gap_used};
    assign w_aqry = '{chunk: r_chunk, used: r_alloc_used};

    always_comb begin
        w_gtok[0]       = '0;
        w_gtok[0].valid = r_gtok_go;
        w_atok[0]       = '0;
        w_atok[0].valid = r_atok_go;
    end

    // tail of the allocation row shifts in an empty entry
    assign w_astart[ALLOC_N]  = '0;
    assign w_achunks[ALLOC_N] = '0;

    for (genvar j = 0; j < GAP_N; j++) begin : g_gap
        bfca_gap_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_idx   (GIDX_W'(j)),
            .i_qry   (w_gqry),
            .i_tok   (w_gtok[j]),
            .i_wr    (r_gwr),
            .o_tok   (w_gtok[j+1])
        );
    end

    for (genvar j = 0; j < ALLOC_N; j++) begin : g_alloc
        bfca_alloc_cell u_cell (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_idx         (AIDX_W'(j)),
            .i_qry         (w_aqry),
            .i_tok         (w_atok[j]),
            .i_wr          (r_awr),
            .i_next_start  (w_astart[j+1]),
            .i_next_chunks (w_achunks[j+1]),
            .o_tok         (w_atok[j+1]),
            .o_start       (w_astart[j]),
            .o_chunks      (w_achunks[j])
        );
    end

    // sequencer
    always_comb begin
        n_state      = r_state;
        n_mib        = r_mib;
        n_gap_used   = r_gap_used;
        n_alloc_used = r_alloc_used;
        n_func       = r_func;
        n_need       = r_need;
        n_chunk      = r_chunk;
        n_s          = r_s;
        n_n          = r_n;
        n_k          = r_k;
        n_gmode      = r_gmode;
        n_gtok_go    = 1'b0;
        n_atok_go    = 1'b0;
        n_gwr        = '0;
        n_gwr.op     = GC_NONE;
        n_awr        = '0;
        n_awr.op     = AC_NONE;
        n_res_addr   = r_res_addr;
        n_res_st     = r_res_st;
        n_out_valid  = r_out_valid && i_out_stall;
        n_out_word   = r_out_word;

        // size write: rebuild both tables
        if (w_cfg_acc) begin
            n_mib        = w_mib_clamp;
            n_gwr.op     = GC_INIT;
            n_gwr.chunks = CHUNKS_W'(w_mib_clamp) << MIB_SHIFT;
            n_awr.op     = AC_CLEAR;
            n_gap_used   = (w_mib_clamp != '0) ? GCNT_W'(1) : '0;
            n_alloc_used = '0;
        end

        case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    n_func     = i_in_word.func;
                    // a count past the chunk field can never fit; pin it to all ones
                    n_need     = w_round[BYTES_W] ? '1 : w_round[BYTES_W-1:CHUNK_SHIFT];
                    n_chunk    = w_offset[ADDR_W-1:CHUNK_SHIFT];
                    n_res_addr = '0;
                    if (r_mib == '0) begin
                        n_res_st = ST_DISABLED;
                        n_state  = S_DONE;
                    end else if (i_in_word.func == FUNC_ALLOC) begin
                        if (i_in_word.request_bytes == '0) begin
                            n_res_st = ST_ZERO;
                            n_state  = S_DONE;
                        end else begin
                            n_gmode   = GM_FIT;
                            n_gtok_go = 1'b1;
                            n_state   = S_GSCAN;
                        end
                    end else if (i_in_word.free_address < BASE_ADDR) begin
                        n_res_st = ST_NOTFOUND;
                        n_state  = S_DONE;
                    end else begin
                        n_atok_go = 1'b1;
                        n_state   = S_ASCAN;
                    end
                end
            end
            S_ASCAN: begin
                if (w_atok[ALLOC_N].valid) begin
                    if (!w_atok[ALLOC_N].found) begin
                        n_res_st = ST_NOTFOUND;
                        n_state  = S_DONE;
                    end else begin
                        n_s       = w_atok[ALLOC_N].start;
                        n_n       = w_atok[ALLOC_N].chunks;
                        n_k       = w_atok[ALLOC_N].idx;
                        n_gmode   = GM_MERGE;
                        n_gtok_go = 1'b1;
                        n_state   = S_GSCAN;
                    end
                end
            end
            S_GSCAN: begin
                if (w_gtok[GAP_N].valid) begin
                    n_state = S_DONE;
                    if (r_func == FUNC_ALLOC) begin
                        if (!w_gtok[GAP_N].found) begin
                            n_res_st = ST_NOFIT;
                        end else if (r_alloc_used == ACNT_W'(ALLOC_N)) begin
                            n_res_st = ST_FULL;
                        end else begin
                            n_res_st     = ST_OK;
                            n_res_addr   = BASE_ADDR +
                                           (ADDR_W'(w_gtok[GAP_N].start) << CHUNK_SHIFT);
                            n_gwr.op     = GC_CARVE;
                            n_gwr.idx    = w_gtok[GAP_N].idx;
                            n_gwr.chunks = r_need;
                            n_awr.op     = AC_APPEND;
                            n_awr.idx    = r_alloc_used[AIDX_W-1:0];
                            n_awr.start  = w_gtok[GAP_N].start;
                            n_awr.chunks = r_need;
                            n_alloc_used = r_alloc_used + 1'b1;
                        end
                    end else if (!w_gtok[GAP_N].found) begin
                        // no slot can take the block; allocation stays
                        n_res_st = ST_FULL;
                    end else begin
                        n_res_st     = ST_OK;
                        n_gwr.idx    = w_gtok[GAP_N].idx;
                        n_gwr.start  = r_s;
                        n_gwr.chunks = r_n;
                        case (w_gtok[GAP_N].merge)
                            MG_EMPTY: begin
                                n_gwr.op = GC_FILL;
                                if (r_gap_used <= {1'b0, w_gtok[GAP_N].idx})
                                    n_gap_used = {1'b0, w_gtok[GAP_N].idx} + 1'b1;
                            end
                            MG_BELOW: n_gwr.op = GC_GROW_UP;
                            MG_ABOVE: n_gwr.op = GC_GROW_DOWN;
                            default:  n_gwr.op = GC_NONE;
                        endcase
                        n_awr.op     = AC_REMOVE;
                        n_awr.idx    = r_k;
                        n_alloc_used = r_alloc_used - 1'b1;
                    end
                end
            end
            S_DONE: begin
                // table writes land this cycle; result leaves once the slot is free
                if (w_out_free) begin
                    n_out_valid                = 1'b1;
                    n_out_word.granted_address = (r_res_st == ST_OK) ? r_res_addr : '0;
                    n_out_word.status          = r_res_st;
                    n_state                    = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_mib        <= '0;
            r_gap_used   <= '0;
            r_alloc_used <= '0;
            r_gtok_go    <= 1'b0;
            r_atok_go    <= 1'b0;
            r_gwr        <= '{op: GC_NONE, default: '0};
            r_awr        <= '{op: AC_CLEAR, default: '0};
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_mib        <= n_mib;
            r_gap_used   <= n_gap_used;
            r_alloc_used <= n_alloc_used;
            r_gtok_go    <= n_gtok_go;
            r_atok_go    <= n_atok_go;
            r_gwr        <= n_gwr;
            r_awr        <= n_awr;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_func     <= n_func;
        r_need     <= n_need;
        r_chunk    <= n_chunk;
        r_s        <= n_s;
        r_n        <= n_n;
        r_k        <= n_k;
        r_gmode    <= n_gmode;
        r_res_addr <= n_res_addr;
        r_res_st   <= n_res_st;
        r_out_word <= n_out_word;
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_cfg_ready = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    // a search word reaches the row end only while its walk is awaited
    a_gtok_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_gtok[GAP_N].valid |-> (r_state == S_GSCAN))
        else $error("gap search word arrived outside gap walk");

    a_atok_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_atok[ALLOC_N].valid |-> (r_state == S_ASCAN))
        else $error("allocation search word arrived outside lookup walk");

    a_alloc_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_alloc_used <= ACNT_W'(ALLOC_N))
        else $error("allocation count beyond table");

    a_gap_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_gap_used <= GCNT_W'(GAP_N))
        else $error("gap scan range beyond table");

    a_out_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state == S_DONE))
        else $error("result word raised without a finished request");

endmodule

`default_nettype wire

// ===== src/bfca_gap_cell.sv =====
// ============================================================================
// bfca_gap_cell - one gap table entry
// Updates the passing search word and applies broadcast write commands.
// ============================================================================
`default_nettype none

module bfca_gap_cell (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic [bfca_pkg::GIDX_W-1:0]   i_idx,
    input  wire bfca_pkg::t_gqry               i_qry,
    input  wire bfca_pkg::t_gtok               i_tok,
    input  wire bfca_pkg::t_gwr                i_wr,
    output bfca_pkg::t_gtok                    o_tok
);
    import bfca_pkg::*;

    logic [START_W-1:0]  r_start;
    logic [CHUNKS_W-1:0] r_chunks;
    t_gtok               r_tok;
    t_gtok               n_tok;
    logic [CHUNKS_W:0]   w_end;
    logic [CHUNKS_W:0]   w_blk_end;
    logic [CHUNKS_W-1:0] w_carve_sum;

    assign w_end       = {2'b00, r_start} + {1'b0, r_chunks};
    assign w_blk_end   = {2'b00, i_qry.s} + {1'b0, i_qry.n};
    assign w_carve_sum = {1'b0, r_start} + i_wr.chunks;

    always_comb begin
        n_tok = i_tok;
        if (i_tok.valid) begin
            case (i_qry.mode)
                GM_FIT: begin
                    if (!i_tok.exact && ({1'b0, i_idx} < i_qry.used)) begin
                        if (r_chunks == i_qry.need) begin
                            n_tok.found  = 1'b1;
                            n_tok.exact  = 1'b1;
                            n_tok.idx    = i_idx;
                            n_tok.chunks = r_chunks;
                            n_tok.start  = r_start;
                        end else if (r_chunks > i_qry.need &&
                                     (!i_tok.found || r_chunks <= i_tok.chunks)) begin
                            n_tok.found  = 1'b1;
                            n_tok.idx    = i_idx;
                            n_tok.chunks = r_chunks;
                            n_tok.start  = r_start;
                        end
                    end
                end
                GM_MERGE: begin
                    if (!i_tok.found) begin
                        if (r_chunks == '0) begin
                            n_tok.found = 1'b1;
                            n_tok.idx   = i_idx;
                            n_tok.merge = MG_EMPTY;
                        end else if (w_end == {2'b00, i_qry.s}) begin
                            n_tok.found = 1'b1;
                            n_tok.idx   = i_idx;
                            n_tok.merge = MG_BELOW;
                        end else if (w_blk_end == {2'b00, r_start}) begin
                            n_tok.found = 1'b1;
                            n_tok.idx   = i_idx;
                            n_tok.merge = MG_ABOVE;
                        end
                    end
                end
                default: n_tok = i_tok;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok <= '0;
        end else begin
            r_tok <= n_tok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chunks    <= '0;
        end else if (i_wr.op == GC_INIT) begin
            r_start  <= '0;
            r_chunks <= (i_idx == '0) ? i_wr.chunks : '0;
        end else if (i_wr.idx == i_idx) begin
            case (i_wr.op)
                GC_CARVE: begin
                    r_start  <= w_carve_sum[START_W-1:0];
                    r_chunks <= r_chunks - i_wr.chunks;
                end
                GC_FILL: begin
                    r_start  <= i_wr.start;
                    r_chunks <= i_wr.chunks;
                end
                GC_GROW_UP: begin
                    r_chunks <= r_chunks + i_wr.chunks;
                end
                GC_GROW_DOWN: begin
                    r_start  <= i_wr.start;
                    r_chunks <= r_chunks + i_wr.chunks;
                end
                default: r_chunks <= r_chunks;
            endcase
        end
    end

    assign o_tok = r_tok;

endmodule

`default_nettype wire

// ===== src/bfca_alloc_cell.sv =====
// ============================================================================
// bfca_alloc_cell - one allocation table entry
// Matches the passing lookup word; shifts down from its neighbor on remove.
// ============================================================================
`default_nettype none

module bfca_alloc_cell (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic [bfca_pkg::AIDX_W-1:0]     i_idx,
    input  wire bfca_pkg::t_aqry                 i_qry,
    input  wire bfca_pkg::t_atok                 i_tok,
    input  wire bfca_pkg::t_awr                  i_wr,
    input  wire logic [bfca_pkg::START_W-1:0]    i_next_start,
    input  wire logic [bfca_pkg::CHUNKS_W-1:0]   i_next_chunks,
    output bfca_pkg::t_atok                      o_tok,
    output logic [bfca_pkg::START_W-1:0]         o_start,
    output logic [bfca_pkg::CHUNKS_W-1:0]        o_chunks
);
    import bfca_pkg::*;

    logic [START_W-1:0]  r_start;
    logic [CHUNKS_W-1:0] r_chunks;
    t_atok               r_tok;
    t_atok               n_tok;

    always_comb begin
        n_tok = i_tok;
        if (i_tok.valid && !i_tok.found && ({1'b0, i_idx} < i_qry.used) &&
            ({{(CIDX_W-START_W){1'b0}}, r_start} == i_qry.chunk)) begin
            n_tok.found  = 1'b1;
            n_tok.idx    = i_idx;
            n_tok.start  = r_start;
            n_tok.chunks = r_chunks;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok <= '0;
        end else begin
            r_tok <= n_tok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chunks    <= '0;
        end else begin
            case (i_wr.op)
                AC_CLEAR: r_chunks <= '0;
                AC_APPEND: begin
                    if (i_wr.idx == i_idx) begin
                        r_start  <= i_wr.start;
                        r_chunks <= i_wr.chunks;
                    end
                end
                AC_REMOVE: begin
                    if (i_idx >= i_wr.idx) begin
                        r_start  <= i_next_start;
                        r_chunks <= i_next_chunks;
                    end
                end
                default: r_chunks <= r_chunks;
            endcase
        end
    end

    assign o_tok    = r_tok;
    assign o_start  = r_start;
    assign o_chunks = r_chunks;

endmodule

`default_nettype wire

// ===== dv/tb.sv =====
`timescale 1ns / 1ps
// ============================================================================
// tb - testbench of the best-fit chunk allocator
// Drives allocate and free words through several memory sizes and idle
// patterns, predicts every result word and checks it in order.
// ============================================================================
`default_nettype none

module tb;
    import bfca_pkg::*;

    // Predicts each result word from the accepted request words and checks the
    // words that come out against those predictions, oldest first.
    class alloc_scoreboard;
        int unsigned gap_pos   [GAP_N];
        int unsigned gap_len   [GAP_N];
        int unsigned gap_slots;
        int unsigned held_pos  [ALLOC_N];
        int unsigned held_len  [ALLOC_N];
        int unsigned held_cnt;
        int unsigned mem_mib;
        t_out_word   pending_q[$];
        int          errors;

        function void clear_tables();
            for (int i = 0; i < GAP_N; i++) begin
                gap_pos[i] = 0;
                gap_len[i] = 0;
            end
            for (int i = 0; i < ALLOC_N; i++) begin
                held_pos[i] = 0;
                held_len[i] = 0;
            end
            gap_slots = 0;
            held_cnt  = 0;
        endfunction

        function void set_size(logic [MIB_W-1:0] mib);
            mem_mib = (mib > MAX_MIB) ? MAX_MIB : mib;
            clear_tables();
            if (mem_mib != 0) begin
                gap_len[0] = (mem_mib * 1048576) / CHUNK_BYTES;
                gap_slots  = 1;
            end
        endfunction

        function t_status carve(logic [BYTES_W-1:0] bytes, output logic [ADDR_W-1:0] addr);
            int unsigned need, best, pos;
            bit          found;
            need  = (bytes + CHUNK_BYTES - 1) / CHUNK_BYTES;
            best  = 0;
            found = 0;
            addr  = '0;
            if (bytes == 0) return ST_ZERO;
            for (int i = 0; i < gap_slots && i < GAP_N; i++) begin
                if (gap_len[i] == need) begin
                    best  = i;
                    found = 1;
                    break;
                end
                // smallest larger gap, the later one taking ties
                if (gap_len[i] > need && (!found || gap_len[i] <= gap_len[best])) begin
                    best  = i;
                    found = 1;
                end
            end
            if (!found) return ST_NOFIT;
            if (held_cnt >= ALLOC_N) return ST_FULL;
            pos = gap_pos[best];
            gap_len[best] -= need;
            gap_pos[best] = (pos + need) & 32'h1FFFF;
            held_pos[held_cnt] = pos;
            held_len[held_cnt] = need;
            held_cnt++;
            addr = ADDR_W'((BASE_ADDR + pos * CHUNK_BYTES) & 32'h7FFF_FFFF);
            return ST_OK;
        endfunction

        function t_status release_block(logic [ADDR_W-1:0] addr);
            int unsigned chunk, k, i, s, n;
            bit          found;
            found = 0;
            if (addr < BASE_ADDR) return ST_NOTFOUND;
            chunk = (addr - BASE_ADDR) / CHUNK_BYTES;
            for (k = 0; k < held_cnt && k < ALLOC_N; k++) begin
                if (held_pos[k] == chunk) begin
                    found = 1;
                    break;
                end
            end
            if (!found) return ST_NOTFOUND;
            s = held_pos[k];
            n = held_len[k];
            // first slot that is empty or touches the freed block wins
            for (i = 0; i < GAP_N; i++) begin
                if (gap_len[i] == 0 || gap_pos[i] + gap_len[i] == s || s + n == gap_pos[i])
                    break;
            end
            if (i >= GAP_N) return ST_FULL;
            if (gap_len[i] == 0) begin
                gap_pos[i] = s;
                gap_len[i] = n;
                if (gap_slots <= i) gap_slots = i + 1;
            end else if (gap_pos[i] + gap_len[i] == s) begin
                gap_len[i] += n;
            end else begin
                gap_pos[i] = s;
                gap_len[i] += n;
            end
            for (; k + 1 < held_cnt; k++) begin
                held_pos[k] = held_pos[k + 1];
                held_len[k] = held_len[k + 1];
            end
            held_cnt--;
            held_pos[held_cnt] = 0;
            held_len[held_cnt] = 0;
            return ST_OK;
        endfunction

        // note an accepted request word; returns the predicted result word
        function t_out_word note_request(t_in_word w);
            t_out_word   r;
            logic [ADDR_W-1:0] a;
            t_status     st;
            a = '0;
            if (mem_mib == 0) st = ST_DISABLED;
            else if (w.func == FUNC_ALLOC) st = carve(w.request_bytes, a);
            else st = release_block(w.free_address);
            r.granted_address = (st == ST_OK) ? a : '0;
            r.status          = st;
            pending_q.push_back(r);
            return r;
        endfunction

        function void check_result(t_out_word got);
            t_out_word exp_w;
            if (pending_q.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("tb: unexpected result word addr=%h status=%0d",
                             got.granted_address, got.status);
                return;
            end
            exp_w = pending_q.pop_front();
            if (got.granted_address !== exp_w.granted_address ||
                got.status !== exp_w.status) begin
                errors++;
                if (errors <= 10)
                    $display("tb: mismatch exp addr=%h status=%0d got addr=%h status=%0d",
                             exp_w.granted_address, exp_w.status,
                             got.granted_address, got.status);
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    t_in_word    i_in_word;
    logic        o_out_valid;
    logic        i_out_stall;
    t_out_word   o_out_word;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [MIB_W-1:0] i_cfg_data;

    alloc_scoreboard   sb;
    logic [ADDR_W-1:0] live_q[$];     // granted addresses not yet freed
    int                send_idle_pct;
    int                recv_idle_pct;

    best_fit_chunk_allocator_unit u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_word  (o_out_word),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // receiver back-pressure, redrawn every cycle
    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    // result monitor: a word moves when valid is high and stall is low
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            sb.check_result(o_out_word);
    end

    // hard stop well past the slowest legal run
    initial begin
        #20_000_000;
        $display("tb: FAIL");
        $finish;
    end

    // one request word; holds valid and payload until accepted
    task automatic send_word(t_in_word w);
        t_out_word r;
        int unsigned chunk;
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_word  <= w;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        r = sb.note_request(w);
        // keep the list of live blocks in step with the prediction
        if (r.status == ST_OK && w.func == FUNC_ALLOC) begin
            live_q.push_back(r.granted_address);
        end else if (r.status == ST_OK) begin
            chunk = (w.free_address - BASE_ADDR) / CHUNK_BYTES;
            foreach (live_q[j]) begin
                if ((live_q[j] - BASE_ADDR) / CHUNK_BYTES == chunk) begin
                    live_q.delete(j);
                    break;
                end
            end
        end
    endtask

    task automatic request(logic fn, logic [BYTES_W-1:0] bytes, logic [ADDR_W-1:0] addr);
        t_in_word w;
        w.func          = fn;
        w.request_bytes = bytes;
        w.free_address  = addr;
        send_word(w);
    endtask

    // size writes happen only with the block drained
    task automatic write_size(logic [MIB_W-1:0] mib);
        i_in_valid <= 1'b0;
        while (sb.pending_q.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= mib;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        sb.set_size(mib);
        live_q.delete();
    endtask

    task automatic random_word();
        logic [BYTES_W-1:0] bytes;
        logic [ADDR_W-1:0]  addr;
        int                 pick;
        bytes = BYTES_W'($urandom_range(9000, 1));
        case ($urandom_range(19))
            0:       bytes = '0;
            1, 2:    bytes = BYTES_W'($urandom_range(16777216));
            3:       bytes = BYTES_W'($urandom_range(128, 1));
            default: ;
        endcase
        addr = ADDR_W'($urandom & 32'h7FFF_FFFF);
        // free a live block in 45 percent of draws or once 34 are live, else mostly alloc
        if ((live_q.size() > 0 && $urandom_range(99) < 45) || live_q.size() >= 34) begin
            pick = $urandom_range(live_q.size() - 1);
            addr = live_q[pick];
            if ($urandom_range(3) == 0)
                addr = ADDR_W'(addr + $urandom_range(CHUNK_BYTES - 1));
            request(FUNC_FREE, bytes, addr);
        end else if ($urandom_range(9) == 0) begin
            if ($urandom_range(1))
                addr = ADDR_W'(BASE_ADDR + ($urandom_range(4095) << CHUNK_SHIFT));
            request(FUNC_FREE, bytes, addr);
        end else begin
            request(FUNC_ALLOC, bytes, addr);
        end
    endtask

    initial begin
        logic [MIB_W-1:0] sizes [6];
        int               counts[6];
        sizes  = '{5'd16, 5'd1, 5'd31, 5'd0, 5'd2, 5'd16};
        counts = '{150, 150, 150, 20, 150, 150};
        sb = new();
        sb.set_size('0);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_in_word   = '0;
        i_out_stall = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_data  = '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // disabled after reset
        request(FUNC_ALLOC, 25'd128, '0);
        request(FUNC_FREE, '0, BASE_ADDR);
        write_size(5'd16);
        request(FUNC_ALLOC, '0, '0);                          // zero size
        request(FUNC_ALLOC, 25'd1, '1);
        request(FUNC_ALLOC, 25'd128, '0);
        request(FUNC_ALLOC, 25'd129, '0);
        request(FUNC_ALLOC, 25'd16777216, '0);                // no fit
        request(FUNC_FREE, '1, 31'd0);                        // below base
        request(FUNC_FREE, '0, 31'h7FFF_FFFF);                // unknown
        request(FUNC_FREE, '0,
                ADDR_W'(BASE_ADDR + 31'd1 * CHUNK_BYTES + 31'd5));  // truncated offset
        request(FUNC_FREE, '0, BASE_ADDR);                    // merges with a neighbor
        request(FUNC_ALLOC, 25'd256, '0);                     // exact fit
        write_size(5'd1);
        request(FUNC_ALLOC, 25'd1048576, '0);                 // whole memory
        request(FUNC_ALLOC, 25'd1, '0);                       // nothing left
        request(FUNC_FREE, '0, BASE_ADDR);

        for (int p = 0; p < 6; p++) begin
            send_idle_pct = (p < 2) ? 30 : (p < 4) ? 61 : 0;
            recv_idle_pct = (p < 2) ? 61 : (p < 4) ? 30 : 0;
            write_size(sizes[p]);
            for (int n = 0; n < counts[p]; n++) random_word();
        end
        i_in_valid <= 1'b0;

        while (sb.pending_q.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending_q.size() == 0) begin
            $display("tb: PASS");
        end else begin
            $display("tb: FAIL");
        end
        $finish;
    end
endmodule

`default_nettype wire
